@@ rtl/hbrp_pkg.sv @@
// hbrp_pkg: shared types, constants and the prefix character function for the http byte range parser
// no dependencies
`default_nettype none

package hbrp_pkg;

    localparam int POS_W    = 48;
    localparam int LEN_W    = 48;
    localparam int EXT_W    = 64;
    localparam int DATA_W   = 64;
    localparam int ADDR_W   = 4;
    localparam int PFX_LEN  = 6;

    localparam logic [0:0] REG_TOTAL_LENGTH = 1'b0;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       is_last;
    } t_in_beat;

    typedef struct packed {
        logic             range_valid;
        logic [LEN_W-1:0] range_offset;
        logic [LEN_W-1:0] range_count;
    } t_out_beat;

    // state of one header captured on its last beat
    typedef struct packed {
        logic             phase_ok;
        logic             ovf;
        logic [POS_W-1:0] start_pos;
        logic [POS_W-1:0] stop_pos;
    } t_fin;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h62;
            3'd1:    c = 8'h79;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h73;
            3'd5:    c = 8'h3d;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/http_byte_range_parser.sv @@
// http_byte_range_parser: parses a range header one byte a beat, one result per header
// depends on hbrp_pkg
// a result beat is registered in r_out once the captured header in r_fin can move on
// throughput: one byte per cycle while o_in_stall is low, set by the parse and accumulate step
// the result stage (subtract and compare) runs in parallel with parsing of the next header
// reset: synchronous active-low i_rst_n clears the parse state, pipeline valids and total_length
`default_nettype none

module http_byte_range_parser (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  hbrp_pkg::t_in_beat            i_in_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output hbrp_pkg::t_out_beat                 o_out_data,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [hbrp_pkg::ADDR_W-1:0]         paddr,
    input  wire  [hbrp_pkg::DATA_W-1:0]         pwdata,
    output logic [hbrp_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import hbrp_pkg::*;

    localparam logic [3:0] PH_PREFIX_WAIT = 4'd0;
    localparam logic [3:0] PH_PREFIX_MID  = 4'd1;
    localparam logic [3:0] PH_FROM_FIRST  = 4'd2;
    localparam logic [3:0] PH_FROM_DIGITS = 4'd3;
    localparam logic [3:0] PH_FROM_SPACE  = 4'd4;
    localparam logic [3:0] PH_TO_FIRST    = 4'd5;
    localparam logic [3:0] PH_TO_DIGITS   = 4'd6;
    localparam logic [3:0] PH_DONE        = 4'd7;
    localparam logic [3:0] PH_REJECT      = 4'd8;

    logic [LEN_W-1:0]  r_total;
    logic [3:0]        r_phase, n_phase;
    logic [2:0]        r_idx, n_idx;
    logic [POS_W-1:0]  r_start, n_start;
    logic [POS_W-1:0]  r_stop, n_stop;
    logic              r_ovf, n_ovf;
    logic              r_fin_valid;
    t_fin              r_fin;
    logic              r_out_valid;
    t_out_beat         r_out;

    logic              cfg_wr;
    logic              out_free;
    logic              fin_move;
    logic              in_acc;
    logic [7:0]        c;
    logic              is_digit;
    logic [3:0]        d;
    logic [POS_W-1:0]  acc_src;
    logic [POS_W+3:0]  acc;
    logic              acc_ovf;
    logic [EXT_W-1:0]  tl_ext;
    logic              tl_ovf;
    logic [POS_W-1:0]  tl_pos;
    logic [POS_W:0]    diff;
    logic              gt;
    logic [EXT_W-1:0]  off_ext;
    logic [EXT_W-1:0]  cnt_ext;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[ADDR_W-1:ADDR_W-1] == REG_TOTAL_LENGTH);
    assign prdata = (paddr[ADDR_W-1:ADDR_W-1] == REG_TOTAL_LENGTH)
                    ? {{(DATA_W-LEN_W){1'b0}}, r_total} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (cfg_wr) begin
            r_total <= pwdata[LEN_W-1:0];
        end
    end

    // handshakes
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fin_move   = r_fin_valid && out_free;
    assign o_in_stall = r_fin_valid && !fin_move;
    assign in_acc     = i_in_valid && !o_in_stall;

    // parse step
    assign c        = i_in_data.header_byte;
    assign is_digit = (c >= 8'h30) && (c <= 8'h39);
    assign d        = c[3:0];
    assign acc_src  = (r_phase == PH_FROM_DIGITS) ? r_start : r_stop;
    assign acc      = {1'b0, acc_src, 3'b000} + {3'b000, acc_src, 1'b0}
                      + {{POS_W{1'b0}}, d};
    assign acc_ovf  = |acc[POS_W+3:POS_W];
    assign tl_ext   = {{(EXT_W-LEN_W){1'b0}}, r_total};
    assign tl_ovf   = |(tl_ext >> POS_W);
    assign tl_pos   = tl_ext[POS_W-1:0];

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_start = r_start;
        n_stop  = r_stop;
        n_ovf   = r_ovf;
        priority if (r_phase == PH_DONE) begin
            n_phase = PH_DONE;
        end else if (r_phase > PH_DONE) begin
            n_phase = PH_REJECT;
        end else if (c == 8'h00) begin
            n_phase = (r_phase >= PH_TO_FIRST) ? PH_DONE : PH_REJECT;
        end else begin
            unique case (r_phase)
                PH_PREFIX_WAIT, PH_PREFIX_MID: begin
                    if (c == prefix_char(r_idx)) begin
                        n_idx   = r_idx + 3'd1;
                        n_phase = (r_idx == 3'(PFX_LEN - 1)) ? PH_FROM_FIRST : PH_PREFIX_MID;
                    end else if (r_phase == PH_PREFIX_MID || c != 8'h20) begin
                        n_phase = PH_REJECT;
                    end
                end
                PH_FROM_FIRST: begin
                    if (is_digit) begin
                        n_start = {{(POS_W-4){1'b0}}, d};
                        n_phase = PH_FROM_DIGITS;
                    end else if (c == 8'h2d) begin
                        n_phase = PH_TO_FIRST;
                        n_ovf   = r_ovf | tl_ovf;
                        n_stop  = tl_pos;
                    end else if (c != 8'h20) begin
                        n_phase = PH_REJECT;
                    end
                end
                PH_FROM_DIGITS: begin
                    if (is_digit) begin
                        if (acc_ovf) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_start = acc[POS_W-1:0];
                        end
                    end else if (c == 8'h2d) begin
                        n_phase = PH_TO_FIRST;
                        n_ovf   = r_ovf | tl_ovf;
                        n_stop  = tl_pos;
                    end else if (c == 8'h20) begin
                        n_phase = PH_FROM_SPACE;
                    end else begin
                        n_phase = PH_REJECT;
                    end
                end
                PH_FROM_SPACE: begin
                    if (c == 8'h2d) begin
                        n_phase = PH_TO_FIRST;
                        n_ovf   = r_ovf | tl_ovf;
                        n_stop  = tl_pos;
                    end else if (c != 8'h20) begin
                        n_phase = PH_REJECT;
                    end
                end
                PH_TO_FIRST: begin
                    if (is_digit) begin
                        n_stop  = {{(POS_W-4){1'b0}}, d};
                        n_phase = PH_TO_DIGITS;
                    end else if (c != 8'h20) begin
                        n_phase = PH_REJECT;
                    end
                end
                PH_TO_DIGITS: begin
                    if (is_digit) begin
                        if (acc_ovf) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_stop = acc[POS_W-1:0];
                        end
                    end else if (c == 8'h20) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_REJECT;
                    end
                end
                default: begin
                    n_phase = PH_REJECT;
                end
            endcase
        end
    end

    // parse state, rearmed after every last beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PREFIX_WAIT;
            r_idx   <= '0;
            r_start <= '0;
            r_stop  <= '0;
            r_ovf   <= 1'b0;
        end else if (in_acc) begin
            if (i_in_data.is_last) begin
                r_phase <= PH_PREFIX_WAIT;
                r_idx   <= '0;
                r_start <= '0;
                r_stop  <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_idx   <= n_idx;
                r_start <= n_start;
                r_stop  <= n_stop;
                r_ovf   <= n_ovf;
            end
        end
    end

    // captured header state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (in_acc && i_in_data.is_last) begin
            r_fin_valid <= 1'b1;
        end else if (fin_move) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.is_last) begin
            r_fin.phase_ok  <= (n_phase == PH_TO_FIRST) || (n_phase == PH_TO_DIGITS)
                               || (n_phase == PH_DONE);
            r_fin.ovf       <= n_ovf;
            r_fin.start_pos <= n_start;
            r_fin.stop_pos  <= n_stop;
        end
    end

    // result stage
    assign diff    = {1'b0, r_fin.stop_pos} - {1'b0, r_fin.start_pos};
    assign gt      = !diff[POS_W] && (diff[POS_W-1:0] != '0);
    assign off_ext = {{(EXT_W-POS_W){1'b0}}, r_fin.start_pos};
    assign cnt_ext = {{(EXT_W-POS_W){1'b0}}, diff[POS_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_move) begin
            r_out_valid <= 1'b1;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_move) begin
            if (r_fin.phase_ok && !r_fin.ovf && gt) begin
                r_out.range_valid  <= 1'b1;
                r_out.range_offset <= off_ext[LEN_W-1:0];
                r_out.range_count  <= cnt_ext[LEN_W-1:0];
            end else begin
                r_out.range_valid  <= 1'b0;
                r_out.range_offset <= '0;
                r_out.range_count  <= r_total;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.is_last) |=> (r_phase == PH_PREFIX_WAIT && r_idx == 3'd0
                                          && !r_ovf && r_fin_valid))
        else $error("parser not rearmed after last beat");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.range_valid) |-> (o_out_data.range_count != '0))
        else $error("valid range with zero count");

    a_invalid_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.range_valid)
            |-> (o_out_data.range_offset == '0 && o_out_data.range_count == r_total))
        else $error("invalid result fields wrong");

    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin_valid && !out_free) |=> (r_fin_valid && $stable(r_fin)))
        else $error("captured header lost while output stalled");

    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin_valid && !fin_move) |-> !in_acc)
        else $error("beat accepted while capture stage full");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// testbench for http_byte_range_parser: header bytes in, one range result per header out
// depends on hbrp_pkg and the rtl; self-checking with its own parser model and a result queue
`timescale 1ns / 100ps

module testbench;
    import hbrp_pkg::*;

    typedef enum logic [3:0] {
        SCAN_LEAD, SCAN_PREFIX, FIRST_WAIT, FIRST_DIGITS, FIRST_GAP,
        LAST_WAIT, LAST_DIGITS, SCAN_DONE, SCAN_REJECT
    } t_scan;

    typedef struct {
        string     text;
        int        tail;
        bit        typed;
        t_out_beat want;
    } t_case;

    localparam logic [7:0]        CH_NUL   = 8'h00;
    localparam logic [7:0]        CH_SPACE = 8'h20;
    localparam logic [7:0]        CH_DASH  = 8'h2d;
    localparam logic [7:0]        CH_ZERO  = 8'h30;
    localparam logic [7:0]        CH_NINE  = 8'h39;
    localparam logic [63:0]       POS_LIMIT = 64'h0000_ffff_ffff_ffff;
    localparam logic [LEN_W-1:0]  LEN_ALL  = '1;
    localparam logic [ADDR_W-1:0] ADDR_TOTAL  = {REG_TOTAL_LENGTH, 3'b000};
    localparam logic [ADDR_W-1:0] ADDR_UNUSED = {1'b1, 3'b000};
    localparam int                PHASE_BYTES = 300;
    localparam int                HOLD_CYCLES = 300;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in_beat            i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    t_out_beat           o_out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // parser model state
    t_scan            scan;
    int               unit_pos;
    logic [63:0]      from_pos;
    logic [63:0]      to_pos;
    bit               too_big;
    logic [LEN_W-1:0] len_reg;
    string            unit_text = "bytes=";

    t_out_beat   range_q[$];
    logic [7:0]  hdr_q[$];
    t_out_beat   got_head;
    int          errors;
    bit          hold_request;
    bit          sender_idles;

    http_byte_range_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report(input string msg);
        errors++;
        if (errors <= 40) $display("ERROR: %s", msg);
    endtask

    function automatic void rearm_parser();
        scan     = SCAN_LEAD;
        unit_pos = 0;
        from_pos = '0;
        to_pos   = '0;
        too_big  = 1'b0;
    endfunction

    function automatic logic [63:0] times_ten_plus(input logic [63:0] v, input logic [7:0] c);
        logic [63:0] d;
        d = 64'(c - CH_ZERO);
        if (v > (POS_LIMIT - d) / 10) begin
            too_big = 1'b1;
            return v;
        end
        return v * 10 + d;
    endfunction

    function automatic void take_dash();
        scan   = LAST_WAIT;
        to_pos = {16'd0, len_reg};
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        bit digit;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (scan == SCAN_DONE) return;
        if (scan > SCAN_DONE) begin
            scan = SCAN_REJECT;
            return;
        end
        if (c == CH_NUL) begin
            scan = (scan >= LAST_WAIT) ? SCAN_DONE : SCAN_REJECT;
            return;
        end
        case (scan)
            SCAN_LEAD, SCAN_PREFIX: begin
                if (unit_pos < 6 && c == unit_text[unit_pos]) begin
                    unit_pos++;
                    scan = (unit_pos >= 6) ? FIRST_WAIT : SCAN_PREFIX;
                end else if (scan == SCAN_PREFIX || c != CH_SPACE) begin
                    scan = SCAN_REJECT;
                end
            end
            FIRST_WAIT: begin
                if (digit) begin
                    from_pos = 64'(c - CH_ZERO);
                    scan = FIRST_DIGITS;
                end else if (c == CH_DASH) begin
                    take_dash();
                end else if (c != CH_SPACE) begin
                    scan = SCAN_REJECT;
                end
            end
            FIRST_DIGITS: begin
                if (digit) from_pos = times_ten_plus(from_pos, c);
                else if (c == CH_DASH) take_dash();
                else if (c == CH_SPACE) scan = FIRST_GAP;
                else scan = SCAN_REJECT;
            end
            FIRST_GAP: begin
                if (c == CH_DASH) take_dash();
                else if (c != CH_SPACE) scan = SCAN_REJECT;
            end
            LAST_WAIT: begin
                if (digit) begin
                    to_pos = 64'(c - CH_ZERO);
                    scan = LAST_DIGITS;
                end else if (c != CH_SPACE) begin
                    scan = SCAN_REJECT;
                end
            end
            LAST_DIGITS: begin
                if (digit) to_pos = times_ten_plus(to_pos, c);
                else if (c == CH_SPACE) scan = SCAN_DONE;
                else scan = SCAN_REJECT;
            end
            default: scan = SCAN_REJECT;
        endcase
    endfunction

    function automatic t_out_beat close_header();
        t_out_beat   res;
        logic [63:0] span;
        span = to_pos - from_pos;
        if ((scan == LAST_WAIT || scan == LAST_DIGITS || scan == SCAN_DONE) &&
            !too_big && to_pos > from_pos) begin
            res.range_valid  = 1'b1;
            res.range_offset = from_pos[LEN_W-1:0];
            res.range_count  = span[LEN_W-1:0];
        end else begin
            res.range_valid  = 1'b0;
            res.range_offset = '0;
            res.range_count  = len_reg;
        end
        rearm_parser();
        return res;
    endfunction

    function automatic int gap_cycles();
        int r;
        if (!sender_idles) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_beat(input logic [7:0] b, input bit last, input bit typed,
                             input t_out_beat typed_want);
        int        gap;
        t_out_beat res;
        gap = gap_cycles();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{header_byte: b, is_last: last};
        do @(posedge i_clk); while (o_in_stall);
        parse_char(b);
        if (last) begin
            res = close_header();
            range_q.push_back(typed ? typed_want : res);
        end
    endtask

    task automatic apb_access(input bit wr, input logic [ADDR_W-1:0] addr,
                              input logic [63:0] data, output logic [63:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        if (wr && addr == ADDR_TOTAL) len_reg = data[LEN_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_total_length();
        logic [63:0] rd;
        apb_access(1'b0, ADDR_TOTAL, '0, rd);
        if (rd[LEN_W-1:0] !== len_reg)
            report($sformatf("total_length read %h want %h", rd[LEN_W-1:0], len_reg));
    endtask

    task automatic set_total_length(input logic [63:0] value);
        logic [63:0] rd;
        apb_access(1'b1, ADDR_TOTAL, value, rd);
        check_total_length();
    endtask

    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (range_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) hdr_q.push_back(s[i]);
    endfunction

    function automatic void add_spaces();
        int n;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n) hdr_q.push_back(CH_SPACE);
    endfunction

    function automatic string number_text();
        logic [63:0] v;
        int          mode;
        string       s;
        mode = $urandom_range(0, 9);
        case (mode)
            0, 1, 2, 3, 4: v = 64'($urandom_range(0, 2000));
            5, 6:          v = {$urandom, $urandom} % ({16'd0, len_reg} + 64'd1);
            7:             v = {16'd0, 16'($urandom_range(0, 65535)), $urandom};
            8:             v = POS_LIMIT - 64'd10 + 64'($urandom_range(0, 20));
            default:       v = '0;
        endcase
        if (mode == 9) begin
            s = "";
            repeat ($urandom_range(15, 19)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        end else begin
            s = $sformatf("%0d", v);
        end
        if (mode < 5 && $urandom_range(0, 7) == 0) s = {"0", s};
        return s;
    endfunction

    function automatic void make_header();
        int kind;
        int tail;
        hdr_q.delete();
        kind = $urandom_range(0, 19);
        if (kind >= 18) begin
            repeat ($urandom_range(1, 6))
                hdr_q.push_back(($urandom_range(0, 7) == 0) ? CH_NUL : 8'($urandom_range(0, 255)));
            return;
        end
        add_spaces();
        add_text(unit_text);
        add_spaces();
        if ($urandom_range(0, 3) != 0) begin
            add_text(number_text());
            add_spaces();
        end
        hdr_q.push_back(CH_DASH);
        add_spaces();
        if ($urandom_range(0, 3) != 0) add_text(number_text());
        tail = $urandom_range(0, 5);
        if (tail < 2) begin
            hdr_q.push_back(tail == 0 ? CH_SPACE : CH_NUL);
            repeat ($urandom_range(0, 3)) hdr_q.push_back(8'($urandom_range(0, 255)));
        end
        if (kind >= 15) begin
            if ($urandom_range(0, 1) == 0)
                hdr_q[$urandom_range(0, hdr_q.size() - 1)] = 8'($urandom_range(0, 255));
            else
                while (hdr_q.size() > 1 && $urandom_range(0, 2) != 0) void'(hdr_q.pop_back());
        end
    endfunction

    // result side: random stall runs, one long hold-off on request
    initial begin
        int run;
        bit level;
        int r;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_out_stall <= 1'b1;
                for (run = 0; run < HOLD_CYCLES; run++) @(posedge i_clk);
                hold_request = 1'b0;
                i_out_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 9);
                if (r < 4) begin
                    level = 1'b0;
                    run = $urandom_range(10, 60);
                end else if (r < 8) begin
                    level = 1'b1;
                    run = $urandom_range(1, 3);
                end else if (r == 8) begin
                    level = 1'b0;
                    run = $urandom_range(1, 2);
                end else begin
                    level = 1'b1;
                    run = $urandom_range(15, 50);
                end
                i_out_stall <= level;
                repeat (run - 1) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (range_q.size() == 0) begin
                report("result beat with no header pending");
            end else begin
                got_head = range_q.pop_front();
                if (o_out_data.range_valid !== got_head.range_valid)
                    report($sformatf("range_valid got %b want %b",
                                     o_out_data.range_valid, got_head.range_valid));
                if (o_out_data.range_offset !== got_head.range_offset)
                    report($sformatf("range_offset got %0d want %0d",
                                     o_out_data.range_offset, got_head.range_offset));
                if (o_out_data.range_count !== got_head.range_count)
                    report($sformatf("range_count got %0d want %0d",
                                     o_out_data.range_count, got_head.range_count));
            end
        end
    end

    initial begin
        t_case       cases[4];
        t_out_beat   rejected;
        t_out_beat   no_want;
        logic [63:0] len_plan[5];
        logic [63:0] rd;
        int          sent;
        int          headers;

        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_in_data    <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        errors       = 0;
        hold_request = 1'b0;
        sender_idles = 1'b1;
        len_reg      = '0;
        rearm_parser();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_total_length();
        set_total_length(64'hffff_ffff_ffff_ffff);

        rejected = '{range_valid: 1'b0, range_offset: '0, range_count: LEN_ALL};
        no_want  = '0;
        cases[0] = '{"", 8'hff, 1'b1, rejected};
        cases[1] = '{"", CH_NUL, 1'b1, rejected};
        cases[2] = '{"bytes=-281474976710656", -1, 1'b1, rejected};
        cases[3] = '{"bytes=7-", CH_NUL, 1'b0, no_want};
        foreach (cases[i]) begin
            hdr_q.delete();
            add_text(cases[i].text);
            if (cases[i].tail >= 0) hdr_q.push_back(cases[i].tail[7:0]);
            foreach (hdr_q[k])
                send_beat(hdr_q[k], k == hdr_q.size() - 1,
                          cases[i].typed && k == hdr_q.size() - 1, cases[i].want);
        end

        len_plan = '{64'd0, 64'hffff_0000_0000_0001, 64'd1000,
                     {$urandom, $urandom}, 64'hffff_ffff_ffff_ffff};
        foreach (len_plan[p]) begin
            settle_idle();
            if (p == 0) apb_access(1'b1, ADDR_UNUSED, {$urandom, $urandom}, rd);
            set_total_length(len_plan[p]);
            if (p == 0) check_total_length();
            sent = 0;
            headers = 0;
            while (sent < PHASE_BYTES) begin
                sender_idles = ($urandom_range(0, 3) != 0);
                make_header();
                foreach (hdr_q[k])
                    send_beat(hdr_q[k], k == hdr_q.size() - 1, 1'b0, no_want);
                sent += hdr_q.size();
                headers++;
                if (p == 1 && headers == 4) begin
                    sender_idles = 1'b0;
                    hold_request = 1'b1;
                end
                if (p == 2 && headers == 6) begin
                    i_in_valid <= 1'b0;
                    while (range_q.size() != 0) @(posedge i_clk);
                end
            end
        end

        i_in_valid <= 1'b0;
        while (range_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
